>>> hw/rtl/bnp_pkg.sv
// ----------------------------------------------------------------------------
// Byte to n-bit packer package
// Item types, register indexes and constants shared by the packer.
// ----------------------------------------------------------------------------
package bnp_pkg;

	localparam int unsigned BYTE_BITS = 8;
	localparam int unsigned HELD_BITS = 7;       // pending bits kept between items
	localparam int unsigned SUM_BITS  = 15;      // pending bits plus one element
	localparam int unsigned OUT_DEPTH = 3;       // result buffer entries

	localparam logic [3:0] FIELD_WIDTH_RESET = 4'd8;

	// Configuration register indexes.
	localparam logic [1:0] CFG_FIELD_WIDTH = 2'd0;
	localparam logic [1:0] CFG_BIT_OFFSET  = 2'd1;
	localparam logic [1:0] CFG_PREFIX_BYTE = 2'd2;

	typedef struct packed {
		logic [7:0] element;
		logic       last_element;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} out_item_t;

endpackage

>>> hw/rtl/byte_to_nbit_packer.sv
// ----------------------------------------------------------------------------
// Byte to n-bit packer
// Packs the low field_width bits of each element, LSB first, into bytes.
// ----------------------------------------------------------------------------
// Usage:
// Elements arrive on the in channel (valid/ready). Each contributes its low
// field_width bits (1 to 8; 0 acts as 1, above 8 acts as 8) to a bit stream
// that is cut into bytes on the out channel. The first byte of a job starts
// at offset bit_offset and keeps the bits of prefix_byte below that offset.
// The element flagged last_element flushes any partial byte, and the final
// byte of the job carries last_byte. Registers are written on the cfg channel,
// which is always ready; the user must write them only while the block is
// idle, as the block itself does not enforce this. An accepted item is
// registered in the input stage, then packed into the result buffer, from
// whose head its first byte can be taken.
// Throughput: one item per cycle while each item yields at most one byte and
// the receiver keeps up; the result buffer drains one byte per cycle while
// the receiver is ready, so an item that yields two bytes holds back the next.
// When the receiver stalls, the three-entry result buffer stops taking items
// once it holds two bytes, and in_ready falls as soon as the input stage also
// holds an item.
// Reset clears the job state and the buffer and restores the register
// defaults (field_width 8, bit_offset 0, prefix_byte 0).
// ----------------------------------------------------------------------------
module byte_to_nbit_packer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bnp_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output bnp_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data
);
	import bnp_pkg::*;

	logic [3:0]          field_width_q;
	logic [2:0]          bit_offset_q;
	logic [7:0]          prefix_byte_q;

	in_item_t            item_s1;
	logic                valid_s1;

	logic [HELD_BITS-1:0] acc_q;
	logic [2:0]          held_q;
	logic                started_q;

	out_item_t           buf_q [OUT_DEPTH];
	out_item_t           buf_n [OUT_DEPTH];
	logic [1:0]          cnt_q;
	logic [1:0]          cnt_n;

	logic                adv;
	logic                pop;
	logic [3:0]          eff_width;
	logic [7:0]          elem;
	logic [HELD_BITS-1:0] base_acc;
	logic [2:0]          base_held;
	logic [SUM_BITS-1:0] sum;
	logic [3:0]          held_sum;
	logic                full;
	logic [2:0]          rem;
	logic [HELD_BITS-1:0] after;
	logic                flush;
	logic [1:0]          n_push;
	out_item_t           res_a;
	out_item_t           res_b;
	logic [1:0]          base_idx;
	logic [1:0]          next_idx;

	// Configuration.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_width_q <= FIELD_WIDTH_RESET;
			bit_offset_q  <= 3'd0;
			prefix_byte_q <= 8'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FIELD_WIDTH: field_width_q <= cfg_data[3:0];
				CFG_BIT_OFFSET:  bit_offset_q  <= cfg_data[2:0];
				CFG_PREFIX_BYTE: prefix_byte_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The stage-one item moves on when the buffer has room for two bytes.
	assign adv      = (cnt_q <= 2'd1);
	assign in_ready = !valid_s1 || adv;
	assign pop      = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// Packing logic.
	always_comb begin
		if (field_width_q == 4'd0) begin
			eff_width = 4'd1;
		end else if (field_width_q > 4'd8) begin
			eff_width = 4'd8;
		end else begin
			eff_width = field_width_q;
		end
	end

	assign elem = item_s1.element & 8'(((9'd1 << eff_width) - 9'd1));

	always_comb begin
		if (started_q) begin
			base_acc  = acc_q;
			base_held = held_q;
		end else begin
			// A job starts from the preserved low bits of the prefix byte.
			base_acc  = prefix_byte_q[HELD_BITS-1:0] &
				HELD_BITS'(((8'd1 << bit_offset_q) - 8'd1));
			base_held = bit_offset_q;
		end
	end

	assign sum      = {8'd0, base_acc} | ({7'd0, elem} << base_held);
	assign held_sum = {1'b0, base_held} + eff_width;
	assign full     = held_sum[3];
	assign rem      = held_sum[2:0];
	assign after    = full ? sum[14:8] : sum[6:0];
	assign flush    = item_s1.last_element && (rem != 3'd0);

	always_comb begin
		res_a = '{out_byte: sum[7:0],
			last_byte: item_s1.last_element && (rem == 3'd0)};
		res_b = '{out_byte: {1'b0, after}, last_byte: 1'b1};
		if (!full) begin
			res_a = res_b;
		end
		n_push = {1'b0, full} + {1'b0, flush};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			held_q    <= 3'd0;
			started_q <= 1'b0;
		end else if (valid_s1 && adv) begin
			if (item_s1.last_element) begin
				acc_q     <= '0;
				held_q    <= 3'd0;
				started_q <= 1'b0;
			end else begin
				acc_q     <= after;
				held_q    <= rem;
				started_q <= 1'b1;
			end
		end
	end

	// Result buffer: entry 0 is at the head, new bytes land behind the last one.
	assign base_idx = cnt_q - {1'b0, pop};
	assign next_idx = base_idx + 2'd1;

	always_comb begin
		buf_n = buf_q;
		if (pop) begin
			buf_n[0] = buf_q[1];
			buf_n[1] = buf_q[2];
		end
		if (valid_s1 && adv) begin
			if (n_push != 2'd0) begin
				buf_n[base_idx] = res_a;
			end
			if (n_push == 2'd2) begin
				buf_n[next_idx] = res_b;
			end
		end
		cnt_n = base_idx + ((valid_s1 && adv) ? n_push : 2'd0);
	end

	always_ff @(posedge clk) begin
		buf_q <= buf_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = buf_q[0];

`ifndef SYNTH
	// Between jobs nothing is pending.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!started_q |-> (held_q == 3'd0) && (acc_q == '0))
		else $error("pending bits outside a job");

	// Pending bits above the held count are always clear.
	a_acc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q >> held_q) == '0)
		else $error("stale bits above the held count");

	// The last element of a job always yields at least one byte.
	a_last_yields: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv && item_s1.last_element |-> n_push != 2'd0)
		else $error("last element produced no byte");

	// The final byte pushed for a last element is flagged as such.
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv && item_s1.last_element |->
		((n_push == 2'd2) ? res_b.last_byte : res_a.last_byte))
		else $error("final byte of a job not flagged");
`endif

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Byte to n-bit packer testbench
// Drives elements, register writes and a stalling receiver into the packer,
// predicts every packed byte from its own bit accumulator and checks each
// byte in order as it leaves the block.
// ----------------------------------------------------------------------------
module tb_top;

	import bnp_pkg::*;

	localparam logic [1:0]  CFG_UNUSED   = 2'd3;   // no register behind this index
	localparam int unsigned ITEM_TARGET  = 1950;
	localparam int unsigned QUIET_FROM   = 1650;
	localparam int unsigned DRAIN_SLACK  = 8;
	localparam int unsigned STALL_LIMIT  = 1000;
	localparam int unsigned REPORT_LIMIT = 10;

	// Packer prediction and in-order byte checking.
	class packer_scoreboard;
		logic [3:0]  width_reg;
		logic [2:0]  offset_reg;
		logic [7:0]  prefix_reg;
		logic [14:0] pending;
		int unsigned pending_cnt;
		bit          in_job;
		out_item_t   expected_q[$];
		int unsigned checked;
		int unsigned errors;

		function new();
			width_reg   = FIELD_WIDTH_RESET;
			offset_reg  = '0;
			prefix_reg  = '0;
			pending     = '0;
			pending_cnt = 0;
			in_job      = 1'b0;
			checked     = 0;
			errors      = 0;
		endfunction

		function void write_reg(logic [1:0] index, logic [7:0] data);
			case (index)
				CFG_FIELD_WIDTH: width_reg  = data[3:0];
				CFG_BIT_OFFSET:  offset_reg = data[2:0];
				CFG_PREFIX_BYTE: prefix_reg = data;
				default: ;
			endcase
		endfunction

		function void note_element(in_item_t item);
			int unsigned width;
			int unsigned count;
			logic [15:0] mask;
			logic [15:0] acc;
			out_item_t   byte_out;
			if (width_reg == 4'd0)
				width = 1;
			else if (width_reg > BYTE_BITS)
				width = BYTE_BITS;
			else
				width = width_reg;
			mask = (16'd1 << width) - 16'd1;
			if (!in_job) begin
				pending     = {7'd0, prefix_reg & ((8'd1 << offset_reg) - 8'd1)};
				pending_cnt = offset_reg;
				in_job      = 1'b1;
			end
			acc   = {1'b0, pending} | ((16'(item.element) & mask) << pending_cnt);
			count = pending_cnt + width;
			if (count >= BYTE_BITS) begin
				count              = count - BYTE_BITS;
				byte_out.out_byte  = acc[7:0];
				byte_out.last_byte = item.last_element && (count == 0);
				expected_q.push_back(byte_out);
				acc = acc >> BYTE_BITS;
			end
			pending     = acc[14:0];
			pending_cnt = count;
			if (item.last_element) begin
				// Flush the partial byte; unfilled upper bits stay zero.
				if (count > 0) begin
					byte_out.out_byte  = pending[7:0];
					byte_out.last_byte = 1'b1;
					expected_q.push_back(byte_out);
				end
				pending     = '0;
				pending_cnt = 0;
				in_job      = 1'b0;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("%0t: unexpected byte out_byte=%02h last_byte=%0b",
						$time, got.out_byte, got.last_byte);
			end else begin
				want = expected_q.pop_front();
				checked++;
				if (got.out_byte !== want.out_byte || got.last_byte !== want.last_byte) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("%0t: byte %0d mismatch: expected %02h/%0b, got %02h/%0b",
							$time, checked, want.out_byte, want.last_byte,
							got.out_byte, got.last_byte);
				end
			end
		endfunction
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	in_item_t   in_data   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_item_t  out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data  = '0;

	packer_scoreboard sb;
	bit               quiet;
	int unsigned      gap_odds;
	int unsigned      stall_odds;
	int unsigned      items_sent;
	int unsigned      jobs_closed;
	int unsigned      settings_done;

	byte_to_nbit_packer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				sb.note_element(in_data);
			if (out_valid && out_ready)
				sb.check_result(out_data);
		end
	end

	task automatic send_item(input in_item_t item);
		if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!(in_valid && in_ready));
		items_sent++;
		if (item.last_element)
			jobs_closed++;
	endtask

	// Writes all three registers and then the unused index, which must be ignored.
	task automatic configure(input logic [7:0] width_val, input logic [7:0] offset_val,
			input logic [7:0] prefix_val);
		logic [1:0] index_list [4];
		logic [7:0] data_list [4];
		index_list = '{CFG_FIELD_WIDTH, CFG_BIT_OFFSET, CFG_PREFIX_BYTE, CFG_UNUSED};
		data_list  = '{width_val, offset_val, prefix_val, 8'($urandom)};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= index_list[i];
			cfg_data  <= data_list[i];
			do @(posedge clk); while (!(cfg_valid && cfg_ready));
		end
		cfg_valid <= 1'b0;
		settings_done++;
	endtask

	// Holds the sender off until every predicted byte has left the block.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// Receiver back-pressure.
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!quiet && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	initial begin
		int unsigned idle;
		idle = 0;
		wait (arst_n);
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("Timeout: no transfer for %0d cycles", idle);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		in_item_t    item;
		logic [3:0]  width_pick;
		logic [7:0]  prefix_pick;
		int unsigned phase_len;
		int unsigned job_len;
		int unsigned sent_in_phase;
		sb            = new();
		quiet         = 1'b0;
		gap_odds      = 4;
		stall_odds    = 4;
		items_sent    = 0;
		jobs_closed   = 0;
		settings_done = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full width, whole bytes, job ending exactly on a byte boundary.
		configure(8'h08, 8'h00, 8'h00);
		send_item('{8'hFF, 1'b0});
		send_item('{8'h00, 1'b0});
		send_item('{8'hA5, 1'b1});
		settle();
		// Width field of zero acts as one bit; highest offset, all-ones prefix.
		configure(8'hF0, 8'hFF, 8'hFF);
		send_item('{8'hFF, 1'b0});
		send_item('{8'h00, 1'b0});
		send_item('{8'hFF, 1'b1});
		settle();
		// Width above eight acts as eight; offset and prefix still honoured.
		configure(8'h0F, 8'h03, 8'hA5);
		send_item('{8'hFF, 1'b0});
		send_item('{8'h00, 1'b0});
		send_item('{8'h81, 1'b1});
		settle();
		// Dirty elements, then a register change in the middle of the job.
		configure(8'h03, 8'h05, 8'h5A);
		send_item('{8'hFF, 1'b0});
		send_item('{8'hF8, 1'b0});
		settle();
		configure(8'h05, 8'h02, 8'h33);
		send_item('{8'h1F, 1'b0});
		send_item('{8'hE0, 1'b1});
		settle();
		configure(8'h01, 8'h00, 8'h00);
		send_item('{8'h01, 1'b1});
		settle();
		configure(8'h04, 8'h00, 8'h00);
		send_item('{8'h0F, 1'b0});
		send_item('{8'hF0, 1'b1});
		settle();

		while (items_sent < ITEM_TARGET) begin
			if (items_sent >= QUIET_FROM)
				quiet = 1'b1;
			case ($urandom_range(0, 9))
				0:       width_pick = 4'd0;
				1:       width_pick = 4'($urandom_range(9, 15));
				default: width_pick = 4'($urandom_range(1, 8));
			endcase
			case ($urandom_range(0, 5))
				0:       prefix_pick = 8'h00;
				1:       prefix_pick = 8'hFF;
				default: prefix_pick = 8'($urandom);
			endcase
			configure({4'($urandom), width_pick}, 8'($urandom), prefix_pick);
			gap_odds   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 10);
			stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 10);
			phase_len     = $urandom_range(20, 150);
			sent_in_phase = 0;
			// Jobs of random length; a phase may end inside a job, leaving it open.
			while (sent_in_phase < phase_len) begin
				job_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
					: $urandom_range(1, 12);
				for (int j = 0; j < job_len && sent_in_phase < phase_len; j++) begin
					item.element      = 8'($urandom);
					item.last_element = (j == job_len - 1);
					send_item(item);
					sent_in_phase++;
				end
				if (!quiet && $urandom_range(0, 9) == 0)
					settle();
			end
			settle();
		end

		$display("Sent %0d elements (%0d jobs closed) under %0d register settings.",
			items_sent, jobs_closed, settings_done);
		$display("Checked %0d packed bytes, %0d mismatches, %0d bytes still owed.",
			sb.checked, sb.errors, sb.expected_q.size());
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
